@@ rtl/brf_pkg.sv @@
// Shared constants for the byte ring FIFO: default sizes, field widths,
// request codes and back-end command kinds. No dependencies.
package brf_pkg;

    localparam int BRF_DEPTH     = 1024;
    localparam int BRF_MAX_BURST = 64;
    localparam int BRF_QDEPTH    = 4;

    localparam int BRF_FUNC_W = 2;
    localparam int BRF_LEN_W  = 7;
    localparam int BRF_BYTE_W = 8;
    localparam int BRF_IN_W   = 16;

    localparam logic [BRF_FUNC_W-1:0] FUNC_ENQ  = 2'd0;
    localparam logic [BRF_FUNC_W-1:0] FUNC_DEQ  = 2'd1;
    localparam logic [BRF_FUNC_W-1:0] FUNC_PEEK = 2'd2;
    localparam logic [BRF_FUNC_W-1:0] FUNC_CLR  = 2'd3;

    localparam logic CMD_RESULT = 1'b0;
    localparam logic CMD_READ   = 1'b1;

endpackage

@@ rtl/brf_store.sv @@
// Byte storage of the ring FIFO: one write port, one read port with
// registered read data. Depends on brf_pkg.
module brf_store
    import brf_pkg::*;
#(
    parameter int DEPTH = BRF_DEPTH,
    parameter int PTR_W = $clog2(BRF_DEPTH)
)
(
    input  logic                  clk,
    input  logic                  wr_en,
    input  logic [PTR_W-1:0]      wr_addr,
    input  logic [BRF_BYTE_W-1:0] wr_data,
    input  logic                  rd_en,
    input  logic [PTR_W-1:0]      rd_addr,
    output logic [BRF_BYTE_W-1:0] rd_data
);

    logic [BRF_BYTE_W-1:0] mem_reg [DEPTH];
    logic [BRF_BYTE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/brf_cmdq.sv @@
// Short command queue between the front and back ends of the ring FIFO.
// Depends on brf_pkg.
module brf_cmdq
    import brf_pkg::*;
#(
    parameter int W      = 32,
    parameter int QDEPTH = BRF_QDEPTH
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] push_data,
    output logic         full,
    input  logic         pop,
    output logic [W-1:0] pop_data,
    output logic         empty
);

    localparam int QP_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QC_W = $clog2(QDEPTH + 1);

    logic [W-1:0]    mem_reg [QDEPTH];
    logic [QP_W-1:0] wptr_reg, wptr_next;
    logic [QP_W-1:0] rptr_reg, rptr_next;
    logic [QC_W-1:0] cnt_reg, cnt_next;
    logic            do_push, do_pop;

    assign full     = cnt_reg == QC_W'(QDEPTH);
    assign empty    = cnt_reg == '0;
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rptr_reg];

    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (do_push)
        begin
            wptr_next = (wptr_reg == QP_W'(QDEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rptr_next = (rptr_reg == QP_W'(QDEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wptr_reg] <= push_data;
        end
    end

endmodule

@@ rtl/brf_front.sv @@
// Front end of the ring FIFO: takes requests, keeps pointers, use count and
// burst state, writes enqueue bytes and queues back-end commands. Depends on brf_pkg.
module brf_front
    import brf_pkg::*;
#(
    parameter int DEPTH     = BRF_DEPTH,
    parameter int MAX_BURST = BRF_MAX_BURST,
    parameter int PTR_W     = $clog2(BRF_DEPTH),
    parameter int CNT_W     = $clog2(BRF_DEPTH + 1),
    localparam int CMD_W    = 1 + PTR_W + 2 * BRF_LEN_W + 2 * CNT_W
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [BRF_FUNC_W-1:0] func,
    input  logic [BRF_LEN_W-1:0]  length,
    input  logic [BRF_BYTE_W-1:0] data,
    input  logic                  q_full,
    output logic                  q_push,
    output logic [CMD_W-1:0]      q_cmd,
    input  logic                  rd_fin,
    output logic                  wr_en,
    output logic [PTR_W-1:0]      wr_addr,
    output logic [BRF_BYTE_W-1:0] wr_data
);

    localparam int CW    = (CNT_W > BRF_LEN_W) ? CNT_W : BRF_LEN_W;
    localparam int SUM_W = CW + 1;
    localparam int RP_W  = $clog2(BRF_QDEPTH + 2);

    typedef struct packed {
        logic                 kind;
        logic [PTR_W-1:0]     ptr;
        logic [BRF_LEN_W-1:0] len;
        logic [BRF_LEN_W-1:0] done;
        logic [CNT_W-1:0]     used;
        logic [CNT_W-1:0]     free;
    } cmd_t;

    logic [PTR_W-1:0]     wptr_reg, wptr_next;
    logic [PTR_W-1:0]     rptr_reg, rptr_next;
    logic [CNT_W-1:0]     use_reg, use_next;
    logic [BRF_LEN_W-1:0] left_reg, left_next;
    logic                 ok_reg, ok_next;
    logic [BRF_LEN_W-1:0] blen_reg, blen_next;
    logic [RP_W-1:0]      pend_reg, pend_next;

    cmd_t                 cmd;
    logic                 accept;
    logic                 push_read;
    logic [CNT_W-1:0]     free_now;
    logic [CW-1:0]        len_x, use_x, free_x;
    logic                 max_ok, first;
    logic                 e_ok;
    logic [BRF_LEN_W-1:0] e_len, e_left, e_left_new;
    logic [PTR_W-1:0]     wptr_adv;
    logic [CNT_W-1:0]     use_inc, use_sub, e_use;
    logic                 r_bad;
    logic [SUM_W-1:0]     rsum;
    logic [PTR_W-1:0]     rptr_adv;

    assign in_ready = !q_full && !(func == FUNC_ENQ && pend_reg != '0);
    assign accept   = in_valid && in_ready;

    assign free_now = CNT_W'(DEPTH) - use_reg;
    assign len_x    = CW'(length);
    assign use_x    = CW'(use_reg);
    assign free_x   = CW'(free_now);
    assign max_ok   = length <= BRF_LEN_W'(MAX_BURST);
    assign first    = left_reg == '0;

    assign e_ok       = first ? (length != '0 && max_ok && len_x <= free_x) : ok_reg;
    assign e_len      = first ? length : blen_reg;
    assign e_left     = first ? ((length != '0) ? length : BRF_LEN_W'(1)) : left_reg;
    assign e_left_new = e_left - 1'b1;
    assign wptr_adv   = (wptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
    assign use_inc    = use_reg + 1'b1;
    assign e_use      = e_ok ? use_inc : use_reg;

    assign r_bad    = length == '0 || !max_ok || len_x > use_x;
    assign rsum     = SUM_W'(rptr_reg) + SUM_W'(length);
    assign rptr_adv = (rsum >= SUM_W'(DEPTH)) ? PTR_W'(rsum - SUM_W'(DEPTH)) : PTR_W'(rsum);
    assign use_sub  = use_reg - CNT_W'(length);

    assign wr_addr = wptr_reg;
    assign wr_data = data;
    assign q_cmd   = cmd;

    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        use_next  = use_reg;
        left_next = left_reg;
        ok_next   = ok_reg;
        blen_next = blen_reg;
        wr_en     = 1'b0;
        q_push    = 1'b0;
        push_read = 1'b0;
        cmd.kind  = CMD_RESULT;
        cmd.ptr   = rptr_reg;
        cmd.len   = BRF_LEN_W'(1);
        cmd.done  = '0;
        cmd.used  = use_reg;
        cmd.free  = free_now;
        if (accept)
        begin
            case (func)
                FUNC_ENQ:
                begin
                    left_next = e_left_new;
                    ok_next   = e_ok;
                    blen_next = e_len;
                    if (e_ok)
                    begin
                        wr_en     = 1'b1;
                        wptr_next = wptr_adv;
                        use_next  = use_inc;
                    end
                    if (e_left_new == '0)
                    begin
                        q_push    = 1'b1;
                        cmd.done  = e_ok ? e_len : '0;
                        cmd.used  = e_use;
                        cmd.free  = CNT_W'(DEPTH) - e_use;
                    end
                end
                FUNC_DEQ, FUNC_PEEK:
                begin
                    q_push = 1'b1;
                    if (!r_bad)
                    begin
                        push_read = 1'b1;
                        cmd.kind  = CMD_READ;
                        cmd.len   = length;
                        cmd.done  = length;
                        if (func == FUNC_DEQ)
                        begin
                            rptr_next = rptr_adv;
                            use_next  = use_sub;
                            cmd.used  = use_sub;
                            cmd.free  = CNT_W'(DEPTH) - use_sub;
                        end
                    end
                end
                FUNC_CLR:
                begin
                    q_push    = 1'b1;
                    wptr_next = '0;
                    rptr_next = '0;
                    use_next  = '0;
                    left_next = '0;
                    ok_next   = 1'b0;
                    cmd.used  = '0;
                    cmd.free  = CNT_W'(DEPTH);
                end
                default:
                begin
                    q_push = 1'b0;
                end
            endcase
        end
    end

    always_comb
    begin
        pend_next = pend_reg;
        if (push_read && !rd_fin)
        begin
            pend_next = pend_reg + 1'b1;
        end
        else if (rd_fin && !push_read)
        begin
            pend_next = pend_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            use_reg  <= '0;
            left_reg <= '0;
            ok_reg   <= 1'b0;
            blen_reg <= '0;
            pend_reg <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            use_reg  <= use_next;
            left_reg <= left_next;
            ok_reg   <= ok_next;
            blen_reg <= blen_next;
            pend_reg <= pend_next;
        end
    end

endmodule

@@ rtl/brf_back.sv @@
// Back end of the ring FIFO: pops commands, streams read bytes from the
// store into the output register, or emits single result items. Depends on brf_pkg.
module brf_back
    import brf_pkg::*;
#(
    parameter int DEPTH  = BRF_DEPTH,
    parameter int PTR_W  = $clog2(BRF_DEPTH),
    parameter int CNT_W  = $clog2(BRF_DEPTH + 1),
    localparam int CMD_W = 1 + PTR_W + 2 * BRF_LEN_W + 2 * CNT_W
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_empty,
    output logic                  q_pop,
    input  logic [CMD_W-1:0]      q_cmd,
    output logic                  rd_en,
    output logic [PTR_W-1:0]      rd_addr,
    input  logic [BRF_BYTE_W-1:0] rd_data,
    output logic                  rd_fin,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [BRF_BYTE_W-1:0] out_byte,
    output logic                  has_byte,
    output logic [BRF_LEN_W-1:0]  done_count,
    output logic                  last,
    output logic [CNT_W-1:0]      used_count,
    output logic [CNT_W-1:0]      free_count
);

    typedef struct packed {
        logic                 kind;
        logic [PTR_W-1:0]     ptr;
        logic [BRF_LEN_W-1:0] len;
        logic [BRF_LEN_W-1:0] done;
        logic [CNT_W-1:0]     used;
        logic [CNT_W-1:0]     free;
    } cmd_t;

    cmd_t                 cmd;
    logic                 act_reg, act_next;
    logic                 kind_reg;
    logic [PTR_W-1:0]     ptr_reg, ptr_next;
    logic [BRF_LEN_W-1:0] left_reg, left_next;
    logic [BRF_LEN_W-1:0] done_reg;
    logic [CNT_W-1:0]     used_reg, free_reg;
    logic                 ov_reg, ov_next;
    logic                 has_reg;
    logic [BRF_LEN_W-1:0] odone_reg;
    logic                 olast_reg;
    logic [CNT_W-1:0]     oused_reg, ofree_reg;
    logic                 issue, is_last;

    assign cmd     = q_cmd;
    assign issue   = act_reg && (!ov_reg || out_ready);
    assign is_last = left_reg == BRF_LEN_W'(1);
    assign q_pop   = !act_reg && !q_empty;
    assign rd_en   = issue && kind_reg == CMD_READ;
    assign rd_addr = ptr_reg;
    assign rd_fin  = rd_en && is_last;

    assign out_valid  = ov_reg;
    assign out_byte   = has_reg ? rd_data : '0;
    assign has_byte   = has_reg;
    assign done_count = odone_reg;
    assign last       = olast_reg;
    assign used_count = oused_reg;
    assign free_count = ofree_reg;

    always_comb
    begin
        act_next  = act_reg;
        ptr_next  = ptr_reg;
        left_next = left_reg;
        ov_next   = ov_reg;
        if (q_pop)
        begin
            act_next  = 1'b1;
            ptr_next  = cmd.ptr;
            left_next = (cmd.kind == CMD_READ) ? cmd.len : BRF_LEN_W'(1);
        end
        else if (issue)
        begin
            ptr_next  = (ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : ptr_reg + 1'b1;
            left_next = left_reg - 1'b1;
            act_next  = !is_last;
        end
        if (issue)
        begin
            ov_next = 1'b1;
        end
        else if (out_ready)
        begin
            ov_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg  <= 1'b0;
            ov_reg   <= 1'b0;
            left_reg <= '0;
        end
        else
        begin
            act_reg  <= act_next;
            ov_reg   <= ov_next;
            left_reg <= left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg <= ptr_next;
        if (q_pop)
        begin
            kind_reg <= cmd.kind;
            done_reg <= cmd.done;
            used_reg <= cmd.used;
            free_reg <= cmd.free;
        end
        if (issue)
        begin
            has_reg   <= kind_reg == CMD_READ;
            odone_reg <= done_reg;
            olast_reg <= is_last;
            oused_reg <= used_reg;
            ofree_reg <= free_reg;
        end
    end

endmodule

@@ rtl/byte_ring_fifo_bulk_core.sv @@
// Top level of the byte ring FIFO with all-or-nothing bulk requests.
// Depends on brf_pkg, brf_front, brf_cmdq, brf_store and brf_back.
//
// A circular FIFO of DEPTH bytes. Enqueue bytes that do not close a burst are
// taken one per cycle while the input is not stalled. The last byte of an
// enqueue burst, a clear, a refused request and a dequeue or peek each queue
// one command for the back end. The back end loads each command into its
// registers before it emits anything, and then emits a single result or streams
// a dequeue or peek one byte per cycle from the store's registered read port
// while the output is accepted. Commands pass to the back end through a
// four-entry queue. Input stalls while that queue is full. An enqueue byte
// also waits while dequeue or peek reads are still queued or streaming. The
// store is not cleared at reset and needs no initialization pass. The block
// takes requests from the first cycle after reset.
module byte_ring_fifo_bulk_core
    import brf_pkg::*;
#(
    parameter int DEPTH     = BRF_DEPTH,
    parameter int MAX_BURST = BRF_MAX_BURST,
    localparam int PTR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_W    = $clog2(DEPTH + 1),
    localparam int FLD_W    = BRF_BYTE_W + BRF_LEN_W + 2 * CNT_W,
    localparam int OUT_W    = ((FLD_W + 7) / 8) * 8,
    localparam int CMD_W    = 1 + PTR_W + 2 * BRF_LEN_W + 2 * CNT_W
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [BRF_IN_W-1:0]   s_axis_tdata,   // length, data
    input  logic [BRF_FUNC_W-1:0] s_axis_tuser,   // func
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_W-1:0]      m_axis_tdata,   // out_byte, done_count, used_count, free_count
    output logic                  m_axis_tuser,   // has_byte
    output logic                  m_axis_tlast
);

    logic                  q_push, q_full, q_pop, q_empty;
    logic [CMD_W-1:0]      push_cmd, pop_cmd;
    logic                  rd_fin;
    logic                  wr_en, rd_en;
    logic [PTR_W-1:0]      wr_addr, rd_addr;
    logic [BRF_BYTE_W-1:0] wr_data, rd_data;
    logic [BRF_BYTE_W-1:0] out_byte;
    logic [BRF_LEN_W-1:0]  done_count;
    logic [CNT_W-1:0]      used_count, free_count;

    brf_front #(
        .DEPTH     (DEPTH),
        .MAX_BURST (MAX_BURST),
        .PTR_W     (PTR_W),
        .CNT_W     (CNT_W)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .func     (s_axis_tuser),
        .length   (s_axis_tdata[BRF_LEN_W-1:0]),
        .data     (s_axis_tdata[BRF_LEN_W +: BRF_BYTE_W]),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (push_cmd),
        .rd_fin   (rd_fin),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data)
    );

    brf_cmdq #(
        .W      (CMD_W),
        .QDEPTH (BRF_QDEPTH)
    ) u_cmdq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (pop_cmd),
        .empty     (q_empty)
    );

    brf_store #(
        .DEPTH (DEPTH),
        .PTR_W (PTR_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    brf_back #(
        .DEPTH (DEPTH),
        .PTR_W (PTR_W),
        .CNT_W (CNT_W)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_pop      (q_pop),
        .q_cmd      (pop_cmd),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .rd_fin     (rd_fin),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_byte   (out_byte),
        .has_byte   (m_axis_tuser),
        .done_count (done_count),
        .last       (m_axis_tlast),
        .used_count (used_count),
        .free_count (free_count)
    );

    always_comb
    begin
        m_axis_tdata = '0;
        m_axis_tdata[BRF_BYTE_W-1:0] = out_byte;
        m_axis_tdata[BRF_BYTE_W +: BRF_LEN_W] = done_count;
        m_axis_tdata[BRF_BYTE_W + BRF_LEN_W +: CNT_W] = used_count;
        m_axis_tdata[BRF_BYTE_W + BRF_LEN_W + CNT_W +: CNT_W] = free_count;
    end

endmodule

@@ bench/tb.sv @@
// Self-checking bench for byte_ring_fifo_bulk_core: directed and random request
// streams against an in-bench ring buffer predictor, with random stalls on both sides.
// Depends on brf_pkg and the byte_ring_fifo_bulk_core RTL.
module tb;
    import brf_pkg::*;

    localparam int RING        = BRF_DEPTH;
    localparam int BURST_MAX   = BRF_MAX_BURST;
    localparam int OUT_BITS    = 40;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN       = 32;
    localparam int RANDOM_REQS = 50;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        has_byte;
        logic [6:0]  done_count;
        logic        last;
        logic [10:0] used_count;
        logic [10:0] free_count;
    } fifo_result_t;

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [BRF_IN_W-1:0]   s_axis_tdata;
    logic [BRF_FUNC_W-1:0] s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_BITS-1:0]   m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  m_axis_tlast;

    logic [7:0]   ring_mem [RING];
    int           wr_idx = 0;
    int           rd_idx = 0;
    int           fill = 0;
    int           burst_remaining = 0;
    bit           burst_accept = 1'b0;
    int           burst_size = 0;
    fifo_result_t expected_q [$];

    int requests_sent = 0;
    int results_checked = 0;
    int mismatches = 0;
    int peak_fill = 0;
    int idle_cycles = 0;
    int stall_left = 0;
    bit calm = 1'b0;

    byte_ring_fifo_bulk_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic void push_result(logic [7:0] b, logic hb, int done, logic lst);
        fifo_result_t r;
        r.out_byte   = b;
        r.has_byte   = hb;
        r.done_count = done[6:0];
        r.last       = lst;
        r.used_count = fill[10:0];
        r.free_count = 11'(RING - fill);
        expected_q.push_back(r);
    endfunction

    function automatic void ring_request(logic [1:0] fn, int len, logic [7:0] dat);
        logic [7:0] grabbed [BURST_MAX];
        int p;
        case (fn)
            FUNC_ENQ:
            begin
                if (burst_remaining == 0)
                begin
                    burst_size      = len;
                    burst_remaining = (len != 0) ? len : 1;
                    burst_accept    = len != 0 && len <= BURST_MAX && len <= RING - fill;
                end
                if (burst_accept)
                begin
                    ring_mem[wr_idx] = dat;
                    wr_idx = (wr_idx + 1) % RING;
                    fill++;
                    if (fill > peak_fill)
                        peak_fill = fill;
                end
                burst_remaining--;
                if (burst_remaining == 0)
                    push_result(8'h00, 1'b0, burst_accept ? burst_size : 0, 1'b1);
            end
            FUNC_CLR:
            begin
                wr_idx          = 0;
                rd_idx          = 0;
                fill            = 0;
                burst_remaining = 0;
                burst_accept    = 1'b0;
                push_result(8'h00, 1'b0, 0, 1'b1);
            end
            default:
            begin
                if (len == 0 || len > BURST_MAX || len > fill)
                    push_result(8'h00, 1'b0, 0, 1'b1);
                else
                begin
                    p = rd_idx;
                    for (int i = 0; i < len; i++)
                    begin
                        grabbed[i] = ring_mem[p];
                        p = (p + 1) % RING;
                    end
                    if (fn == FUNC_DEQ)
                    begin
                        rd_idx = p;
                        fill -= len;
                    end
                    for (int i = 0; i < len; i++)
                        push_result(grabbed[i], 1'b1, len, i == len - 1);
                end
            end
        endcase
    endfunction

    task automatic send_req(input logic [1:0] fn, input int len, input int dat);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= fn;
        s_axis_tdata  <= {1'b0, dat[7:0], len[6:0]};
        do
            @(posedge clk);
        while (!s_axis_tready);
        ring_request(fn, len & 127, dat[7:0]);
        requests_sent++;
    endtask

    // first_len < 0 continues a burst already open
    task automatic enq_bytes(input int first_len, input int count);
        for (int i = 0; i < count; i++)
            send_req(FUNC_ENQ, (i == 0 && first_len >= 0) ? first_len : $urandom_range(0, 127),
                     $urandom_range(0, 255));
    endtask

    function automatic int pick_read_len();
        int cap;
        cap = (fill < BURST_MAX) ? fill : BURST_MAX;
        if ($urandom_range(0, 9) == 0 || cap == 0)
        begin
            case ($urandom_range(0, 2))
                0: return 0;
                1: return $urandom_range(BURST_MAX + 1, 127);
                default: return (fill < 127) ? fill + 1 : 127;
            endcase
        end
        return $urandom_range(1, cap);
    endfunction

    task automatic test_refused_requests();
        send_req(FUNC_ENQ, 0, 8'hFF);
        send_req(FUNC_DEQ, 0, 8'h00);
        send_req(FUNC_PEEK, 1, 8'hFF);
        send_req(FUNC_DEQ, 127, 8'h00);
        send_req(FUNC_PEEK, BURST_MAX + 1, 8'h00);
        send_req(FUNC_CLR, 127, 8'hFF);
    endtask

    task automatic test_small_burst_readback();
        send_req(FUNC_ENQ, 4, 8'h00);
        send_req(FUNC_ENQ, 127, 8'hFF);
        send_req(FUNC_ENQ, 0, 8'hA5);
        send_req(FUNC_ENQ, 64, 8'h5A);
        send_req(FUNC_PEEK, 4, 8'h00);
        send_req(FUNC_PEEK, 2, 8'h00);
        send_req(FUNC_DEQ, 1, 8'h00);
        send_req(FUNC_DEQ, BURST_MAX, 8'h00);
        send_req(FUNC_DEQ, 3, 8'h00);
    endtask

    task automatic test_burst_with_reads_and_clear();
        enq_bytes(5, 2);
        send_req(FUNC_PEEK, 2, 8'h00);
        send_req(FUNC_DEQ, 1, 8'h00);
        send_req(FUNC_PEEK, 2, 8'h00);
        enq_bytes(-1, 3);
        send_req(FUNC_DEQ, 4, 8'h00);
        enq_bytes(3, 1);
        send_req(FUNC_CLR, 0, 8'h00);
        enq_bytes(2, 2);
        send_req(FUNC_DEQ, 2, 8'h00);
    endtask

    task automatic test_oversize_burst();
        enq_bytes(BURST_MAX + 1, BURST_MAX + 1);
        send_req(FUNC_PEEK, 1, 8'h00);
    endtask

    task automatic test_fill_and_drain();
        send_req(FUNC_CLR, 0, 8'h00);
        enq_bytes(10, 10);
        send_req(FUNC_PEEK, 10, 8'h00);
        send_req(FUNC_DEQ, 10, 8'h00);
        send_req(FUNC_DEQ, 1, 8'h00);
    endtask

    task automatic test_random_traffic();
        int start, roll, len, room;
        start = requests_sent;
        while (requests_sent - start < RANDOM_REQS || burst_remaining != 0)
        begin
            if (requests_sent - start >= RANDOM_REQS - 30)
                calm = 1'b1;
            roll = $urandom_range(0, 99);
            if (burst_remaining != 0)
            begin
                if (roll < 84)
                    send_req(FUNC_ENQ, $urandom_range(0, 127), $urandom_range(0, 255));
                else if (roll < 96)
                    send_req(roll[0] ? FUNC_DEQ : FUNC_PEEK, pick_read_len(),
                             $urandom_range(0, 255));
                else
                    send_req(FUNC_CLR, $urandom_range(0, 127), $urandom_range(0, 255));
            end
            else if (roll < 45)
            begin
                room = RING - fill;
                if (roll < 2)
                    len = 0;
                else if (roll < 3)
                    len = $urandom_range(BURST_MAX + 1, BURST_MAX + 3);
                else if (room == 0)
                    len = 1;
                else if (roll < 10)
                    len = $urandom_range(1, (room < BURST_MAX) ? room : BURST_MAX);
                else
                    len = $urandom_range(1, (room < 12) ? room : 12);
                send_req(FUNC_ENQ, len, $urandom_range(0, 255));
            end
            else if (roll < 94)
                send_req(roll[0] ? FUNC_DEQ : FUNC_PEEK, pick_read_len(), $urandom_range(0, 255));
            else
                send_req(FUNC_CLR, $urandom_range(0, 127), $urandom_range(0, 255));
        end
    endtask

    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(0, 4);
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    always @(posedge clk)
    begin : check_results
        fifo_result_t seen;
        fifo_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            seen.out_byte   = m_axis_tdata[7:0];
            seen.has_byte   = m_axis_tuser;
            seen.done_count = m_axis_tdata[14:8];
            seen.last       = m_axis_tlast;
            seen.used_count = m_axis_tdata[25:15];
            seen.free_count = m_axis_tdata[36:26];
            results_checked++;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d with nothing pending: byte %02h has %0d done %0d",
                             results_checked, seen.out_byte, seen.has_byte, seen.done_count);
            end
            else
            begin
                want = expected_q.pop_front();
                if (seen !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("#%0d want %02h has %0d done %0d last %0d used %0d free %0d",
                                 results_checked, want.out_byte, want.has_byte, want.done_count,
                                 want.last, want.used_count, want.free_count);
                        $display("#%0d got  %02h has %0d done %0d last %0d used %0d free %0d",
                                 results_checked, seen.out_byte, seen.has_byte, seen.done_count,
                                 seen.last, seen.used_count, seen.free_count);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("no request moved for %0d cycles, %0d results outstanding",
                     STALL_LIMIT, expected_q.size());
            $display("FAIL byte_ring_fifo_bulk_core");
            $finish;
        end
    end

    initial
    begin
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= FUNC_ENQ;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        test_refused_requests();
        test_small_burst_readback();
        test_burst_with_reads_and_clear();
        test_oversize_burst();
        test_fill_and_drain();
        test_random_traffic();
        s_axis_tvalid <= 1'b0;

        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);

        $display("%0d requests sent: refusals, bursts mixed with reads and clears, random mix",
                 requests_sent);
        $display("%0d results checked, peak fill %0d bytes, %0d mismatches",
                 results_checked, peak_fill, mismatches);
        if (mismatches == 0 && expected_q.size() == 0)
            $display("PASS byte_ring_fifo_bulk_core");
        else
            $display("FAIL byte_ring_fifo_bulk_core");
        $finish;
    end

endmodule
